FILE: rtl/core/grs_pkg.sv
// Package with the shared types and constants of the grid reachability search.
package grs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_POP_WAIT,
        ST_PROBE,
        ST_NEIGH,
        ST_DONE
    } grs_state_t;

    typedef struct packed {
        logic load;
        logic write_cell;
        logic clear_step;
        logic seed;
        logic pop;
        logic probe;
        logic neigh_step;
        logic finish;
    } grs_cmd_t;

    typedef struct packed {
        logic map_ready;
        logic trivial;
        logic clear_done;
        logic goal_hit;
        logic queue_empty;
        logic neigh_last;
    } grs_status_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

endpackage

FILE: rtl/core/grs_ctrl.sv
// Controller state machine that sequences map writes and the flood search.
module grs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 opcode,
    input  grs_pkg::grs_status_t status,
    output grs_pkg::grs_cmd_t    cmd,
    output logic                 busy
);
    import grs_pkg::*;

    grs_state_t state_reg;
    grs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = !status.map_ready;
                if (start && status.map_ready)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        cmd.write_cell = 1'b1;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (status.trivial)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.clear_step = 1'b1;
                    if (status.clear_done)
                    begin
                        state_next = ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
                state_next = ST_PROBE;
            end
            ST_POP:
            begin
                if (status.goal_hit || status.queue_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                state_next = ST_NEIGH;
            end
            ST_NEIGH:
            begin
                cmd.neigh_step = 1'b1;
                if (status.neigh_last)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("finish did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_WRITE) |=> !busy)
        else $error("map write left the block busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clear_step, cmd.seed, cmd.pop, cmd.probe, cmd.neigh_step,
            cmd.finish}))
        else $error("more than one command at once");

endmodule

FILE: rtl/core/grs_datapath.sv
// Datapath with the map, visited and queue memories of the flood search.
module grs_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  grs_pkg::grs_cmd_t    cmd,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data,
    input  logic [5:0]           cell_x,
    input  logic [5:0]           cell_y,
    input  logic                 walkable,
    input  logic [5:0]           start_x,
    input  logic [5:0]           start_y,
    input  logic [5:0]           end_x,
    input  logic [5:0]           end_y,
    input  logic [5:0]           block_x,
    input  logic [5:0]           block_y,
    output grs_pkg::grs_status_t status,
    output logic                 result
);
    import grs_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int QW = $clog2(CELLS + 1);

    // Memories.
    logic walk_mem [CELLS];
    logic seen_mem [CELLS];
    logic [AW-1:0] queue_mem [CELLS];

    // The walk map is swept to blocked by a clearing pass after reset.
    logic [AW:0] wclr_reg;
    logic        wclr_done;
    assign wclr_done = wclr_reg[AW];

    logic [6:0] width_reg, height_reg;
    logic [7:0] lim_w_reg, lim_h_reg;
    logic [5:0] sx_reg, sy_reg;
    logic [5:0] gx_reg, gy_reg, bx_reg, by_reg;
    logic [7:0] cx_reg, cy_reg;
    logic [AW:0] clr_reg;
    logic [QW-1:0] head_reg, tail_reg;
    logic [1:0] dir_reg;
    logic       hit_reg, trivial_reg, res_reg;
    logic [AW-1:0] pop_q;
    logic          pop_wait_reg;
    logic          walk_q, seen_q, pass_reg, goal_reg;
    logic [AW-1:0] naddr_reg;

    // Candidate neighbor; its map bits are read in the cycle before it is tested.
    logic [8:0] nx, ny;
    logic       in_grid, cand_pass, cand_goal, cand_ok;
    logic [AW-1:0] naddr;
    always_comb
    begin
        nx = {1'b0, cx_reg};
        ny = {1'b0, cy_reg};
        case (dir_reg)
            2'd0: ny = {1'b0, cy_reg} - 9'd1;
            2'd1: nx = {1'b0, cx_reg} + 9'd1;
            2'd2: ny = {1'b0, cy_reg} + 9'd1;
            default: nx = {1'b0, cx_reg} - 9'd1;
        endcase
        in_grid = !nx[8] && !ny[8] && (nx < {1'b0, lim_w_reg}) && (ny < {1'b0, lim_h_reg});
        naddr = {ny[YW-1:0], nx[XW-1:0]};
        cand_pass = in_grid && !(nx[7:0] == {2'b0, bx_reg} && ny[7:0] == {2'b0, by_reg});
        cand_goal = (nx[7:0] == {2'b0, gx_reg}) && (ny[7:0] == {2'b0, gy_reg});
    end
    assign cand_ok = pass_reg && walk_q && !seen_q;

    logic [AW-1:0] saddr;
    logic          s_inside;
    assign s_inside = ({2'b0, sx_reg} < lim_w_reg) && ({2'b0, sy_reg} < lim_h_reg);
    assign saddr = {sy_reg[YW-1:0], sx_reg[XW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 7'd64;
            height_reg <= 7'd64;
            wclr_reg <= '0;
            hit_reg <= 1'b0;
            res_reg <= 1'b0;
            trivial_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            dir_reg <= '0;
            clr_reg <= '0;
            pop_wait_reg <= 1'b0;
        end
        else
        begin
            pop_wait_reg <= cmd.pop;
            if (cfg_we && cfg_index == CFG_WIDTH) width_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_HEIGHT) height_reg <= cfg_data;
            if (!wclr_done) wclr_reg <= wclr_reg + 1'b1;
            if (cmd.load)
            begin
                trivial_reg <= (start_x == end_x) && (start_y == end_y);
                hit_reg <= 1'b0;
                head_reg <= '0;
                tail_reg <= '0;
                clr_reg <= '0;
                dir_reg <= '0;
            end
            if (cmd.clear_step) clr_reg <= clr_reg + 1'b1;
            if (cmd.pop) head_reg <= head_reg + 1'b1;
            if (cmd.neigh_step)
            begin
                dir_reg <= dir_reg + 2'd1;
                if (cand_ok && !hit_reg)
                begin
                    if (goal_reg)
                        hit_reg <= 1'b1;
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            if (cmd.finish) res_reg <= trivial_reg || hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lim_w_reg <= (width_reg > 7'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : {1'b0, width_reg};
            lim_h_reg <= (height_reg > 7'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, height_reg};
            sx_reg <= start_x;
            sy_reg <= start_y;
            gx_reg <= end_x;
            gy_reg <= end_y;
            bx_reg <= block_x;
            by_reg <= block_y;
        end
        if (cmd.seed)
        begin
            cx_reg <= {2'b0, sx_reg};
            cy_reg <= {2'b0, sy_reg};
        end
        else if (pop_wait_reg)
        begin
            cx_reg <= 8'(pop_q[XW-1:0]);
            cy_reg <= 8'(pop_q[AW-1:XW]);
        end
        if (cmd.probe)
        begin
            pass_reg <= cand_pass;
            goal_reg <= cand_goal;
            naddr_reg <= naddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!wclr_done)
            walk_mem[wclr_reg[AW-1:0]] <= 1'b0;
        else if (cmd.write_cell && ({2'b0, cell_x} < 8'(MAX_WIDTH))
                && ({2'b0, cell_y} < 8'(MAX_HEIGHT)))
            walk_mem[{cell_y[YW-1:0], cell_x[XW-1:0]}] <= walkable;
        if (cmd.clear_step)
            seen_mem[clr_reg[AW-1:0]] <= 1'b0;
        else if (cmd.seed && s_inside)
            seen_mem[saddr] <= 1'b1;
        else if (cmd.neigh_step && cand_ok && !hit_reg)
            seen_mem[naddr_reg] <= 1'b1;
        if (cmd.neigh_step && cand_ok && !hit_reg)
            queue_mem[tail_reg[AW-1:0]] <= naddr_reg;
        if (cmd.probe)
        begin
            walk_q <= walk_mem[naddr];
            seen_q <= seen_mem[naddr];
        end
        if (cmd.pop)
            pop_q <= queue_mem[head_reg[AW-1:0]];
    end

    assign status.map_ready = wclr_done;
    assign status.trivial = trivial_reg;
    assign status.clear_done = (clr_reg == (AW+1)'(CELLS - 1)) && wclr_done;
    assign status.goal_hit = hit_reg;
    assign status.queue_empty = (head_reg == tail_reg);
    assign status.neigh_last = (dir_reg == 2'd3);
    assign result = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue read ran past write");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> head_reg != tail_reg)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.neigh_step && hit_reg) |=> hit_reg)
        else $error("goal flag dropped during search");

endmodule

FILE: rtl/core/grid_reachability_search.sv
// Top level of the grid reachability search: controller plus datapath.
// After reset the map store is swept to blocked over all MAX_WIDTH*MAX_HEIGHT (4096) cells,
// and busy stays high until that sweep ends. A map write leaves busy low. A query clears
// the visited map, seeds the start cell, tests each of the 4 neighbors of a cell in the
// PROBE state (address, registered map read) and the NEIGH state (test), and takes each
// further cell from the queue with a pop and a wait for the registered queue read. Start
// equal to goal skips the search, and done then rises after the CLEAR and DONE states,
// from a register. The reachable answer appears with done for one cycle and cannot be
// held off by the receiver.
module grid_reachability_search
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       opcode,
    input  logic [5:0] cell_x,
    input  logic [5:0] cell_y,
    input  logic       walkable,
    input  logic [5:0] start_x,
    input  logic [5:0] start_y,
    input  logic [5:0] end_x,
    input  logic [5:0] end_y,
    input  logic [5:0] block_x,
    input  logic [5:0] block_y,
    output logic       reachable
);
    import grs_pkg::*;

    grs_cmd_t    cmd;
    grs_status_t status;
    logic        done_reg;

    grs_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    grs_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .walkable  (walkable),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .block_x   (block_x),
        .block_y   (block_y),
        .status    (status),
        .result    (reachable)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else done_reg <= cmd.finish;
    end
    assign done = done_reg;

endmodule
